/* sv/mntp_pkg.sv */
// Package for the melody note token parser: item types, character codes,
// error codes and the equal-temperament frequency table. No dependencies.
`timescale 1ns / 1ps

package mntp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_of_note;
    logic       last_of_melody;
  } mntp_in_t;

  typedef struct packed {
    logic [15:0] frequency_hz;
    logic [16:0] period_us;
    logic [19:0] duration_ms;
    logic        is_rest;
    logic [1:0]  parse_error;
    logic        melody_done;
  } mntp_out_t;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_BAD_LETTER = 2'd1;
  localparam logic [1:0] ERR_BAD_MOD    = 2'd2;
  localparam logic [1:0] ERR_NO_DIGIT   = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_FLAT  = 8'h62;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [9:0]  UNIT_MS_RESET   = 10'd125;
  localparam logic [9:0]  UNITS_DEFAULT   = 10'd4;
  localparam logic [13:0] UNITS_MAX       = 14'd999;
  localparam logic [3:0]  OCTAVE_DEFAULT  = 4'd4;
  localparam logic [19:0] PERIOD_DIVIDEND = 20'd1000000;
  localparam int          DIV_STAGES      = 10;
  localparam logic [3:0]  Q_MAX           = 4'd12;

  function automatic logic [15:0] freq_rom(input logic [3:0] k);
    logic [15:0] v;
    case (k)
      4'd0:    v = 16'd28160;
      4'd1:    v = 16'd29834;
      4'd2:    v = 16'd31608;
      4'd3:    v = 16'd33488;
      4'd4:    v = 16'd35479;
      4'd5:    v = 16'd37589;
      4'd6:    v = 16'd39824;
      4'd7:    v = 16'd42192;
      4'd8:    v = 16'd44701;
      4'd9:    v = 16'd47359;
      4'd10:   v = 16'd50175;
      4'd11:   v = 16'd53159;
      default: v = 16'd28160;
    endcase
    return v;
  endfunction

endpackage

/* sv/melody_note_token_parser_core.sv */
// Top level of the melody note token parser: character parser, frequency
// lookup, duration multiply and a pipelined divider for the period.
// Depends on mntp_pkg.
//
// Usage: characters of a melody arrive on the input channel (in_valid_i,
// in_stall_o, in_item_i), one character per item. Each character that ends a
// note (last_of_note set, or a zero character) produces one result item on
// the output channel (out_valid_o, out_stall_i, out_item_o); other
// characters produce none. The duration unit register is written through
// cfg_valid_i / cfg_ready_o / cfg_data_i; the user must write it only while
// the block is idle, which the block itself does not enforce. Throughput is
// one character per cycle while in_stall_o is low. A result reaches
// out_valid_o through a table lookup and multiply stage, ten divider stages
// that each form two bits of the period from the frequency, and the output register.
// Reset returns the parser to the start of a note, the octave and the
// duration units to 4, the unit to 125 ms, and empties the pipeline.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// stalls the input only once every stage ahead holds a result.
`timescale 1ns / 1ps

module melody_note_token_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mntp_pkg::mntp_in_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mntp_pkg::mntp_out_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [9:0]         cfg_data_i
);
  import mntp_pkg::*;

  typedef enum logic [2:0] {
    PH_LETTER,
    PH_MOD,
    PH_COLON,
    PH_DIGITS,
    PH_SKIP
  } phase_e;

  typedef struct packed {
    logic [7:0] m;
    logic [9:0] units;
    logic       rest;
    logic [1:0] err;
    logic       mel;
  } note_t;

  typedef struct packed {
    logic [15:0] f;
    logic [15:0] rem;
    logic [19:0] quot;
    logic [19:0] dur;
    logic        rest;
    logic [1:0]  err;
    logic        mel;
  } pipe_t;

  phase_e             phase_q, phase_d;
  logic signed [4:0]  off_q, off_d;
  logic [3:0]         oct_q, oct_d;
  logic [9:0]         units_q, units_d;
  logic               rest_q, rest_d;
  logic [1:0]         err_q, err_d;
  logic [9:0]         unit_ms_q;

  logic               vp_q;
  note_t              np_q, np_d;
  logic               emit;
  logic               accept;

  logic [DIV_STAGES:0] vs_q;
  logic [DIV_STAGES:0] rdy_s;
  pipe_t              st_q [DIV_STAGES+1];
  pipe_t              st_d [DIV_STAGES+1];

  logic               vo_q;
  mntp_out_t          out_q, out_d;
  logic               rdy_o, rdy_p;

  // Handshake and ready chain.
  always_comb begin
    rdy_o = !vo_q || !out_stall_i;
    rdy_s[DIV_STAGES] = !vs_q[DIV_STAGES] || rdy_o;
    for (int j = DIV_STAGES - 1; j >= 0; j--) begin
      rdy_s[j] = !vs_q[j] || rdy_s[j+1];
    end
    rdy_p = !vp_q || rdy_s[0];
  end

  assign in_stall_o  = !rdy_p;
  assign accept      = in_valid_i && rdy_p;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vo_q;
  assign out_item_o  = out_q;

  // Character parser.
  always_comb begin
    logic [7:0]  c;
    logic        digit;
    logic        ends;
    logic [13:0] v;
    logic [7:0]  base;
    c       = in_item_i.char_code;
    digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    ends    = in_item_i.last_of_note || (c == CH_NUL);
    v       = '0;
    phase_d = phase_q;
    off_d   = off_q;
    oct_d   = oct_q;
    units_d = units_q;
    rest_d  = rest_q;
    err_d   = err_q;

    if (phase_q == PH_LETTER) begin
      off_d   = 5'sd0;
      rest_d  = 1'b0;
      err_d   = ERR_NONE;
      phase_d = PH_MOD;
      case (c)
        CH_A:    off_d = 5'sd0;
        CH_B:    off_d = 5'sd2;
        CH_C:    off_d = -5'sd9;
        CH_D:    off_d = -5'sd7;
        CH_E:    off_d = -5'sd5;
        CH_F:    off_d = -5'sd4;
        CH_G:    off_d = -5'sd2;
        CH_R:    rest_d = 1'b1;
        default: begin
          err_d   = ERR_BAD_LETTER;
          phase_d = PH_SKIP;
        end
      endcase
    end else if (c != CH_NUL) begin
      case (phase_q)
        PH_MOD: begin
          if (c == CH_SHARP) begin
            if (off_q < 5'sd15) off_d = off_q + 5'sd1;
          end else if (c == CH_FLAT) begin
            if (off_q > -5'sd16) off_d = off_q - 5'sd1;
          end else if (digit) begin
            oct_d = c[3:0];
          end else if (c == CH_COLON) begin
            phase_d = PH_COLON;
          end else begin
            if (err_q == ERR_NONE) err_d = ERR_BAD_MOD;
            phase_d = PH_SKIP;
          end
        end
        PH_COLON: begin
          if (digit) begin
            units_d = {6'd0, c[3:0]};
            phase_d = PH_DIGITS;
          end else begin
            if (err_q == ERR_NONE) err_d = ERR_NO_DIGIT;
            phase_d = PH_SKIP;
          end
        end
        PH_DIGITS: begin
          if (digit) begin
            v = {4'd0, units_q} * 14'd10 + {10'd0, c[3:0]};
            units_d = (v > UNITS_MAX) ? UNITS_MAX[9:0] : v[9:0];
          end else begin
            phase_d = PH_SKIP;
          end
        end
        default: begin
        end
      endcase
    end

    if (ends && phase_d == PH_COLON) begin
      if (err_d == ERR_NONE) err_d = ERR_NO_DIGIT;
      phase_d = PH_SKIP;
    end

    base     = {1'b0, oct_d, 3'd0} + {2'd0, oct_d, 2'd0} + 8'd24;
    np_d.m     = base + {{3{off_d[4]}}, off_d};
    np_d.units = units_d;
    np_d.rest  = rest_d;
    np_d.err   = err_d;
    np_d.mel   = in_item_i.last_of_melody;
    emit       = ends;

    if (ends) begin
      phase_d = PH_LETTER;
      off_d   = 5'sd0;
      rest_d  = 1'b0;
      err_d   = ERR_NONE;
      if (in_item_i.last_of_melody) begin
        oct_d   = OCTAVE_DEFAULT;
        units_d = UNITS_DEFAULT;
      end
    end
  end

  // Frequency lookup, duration multiply and divider stages.
  always_comb begin
    logic [15:0] prod;
    logic [3:0]  q;
    logic [7:0]  k;
    logic [16:0] r;
    prod = {8'd0, np_q.m} * 16'd171;
    q    = prod[14:11];
    if (q > Q_MAX) q = Q_MAX;
    k    = np_q.m - {q, 3'd0} - {1'b0, q, 2'd0};
    st_d[0].f    = (np_q.rest || np_q.err != ERR_NONE) ? 16'd0
                   : (freq_rom(k[3:0]) >> (Q_MAX - q));
    st_d[0].rem  = '0;
    st_d[0].quot = '0;
    st_d[0].dur  = {10'd0, np_q.units} * {10'd0, unit_ms_q};
    st_d[0].rest = np_q.rest;
    st_d[0].err  = np_q.err;
    st_d[0].mel  = np_q.mel;
    for (int j = 1; j <= DIV_STAGES; j++) begin
      st_d[j] = st_q[j-1];
      for (int b = 0; b < 2; b++) begin
        r = {st_d[j].rem, PERIOD_DIVIDEND[19 - 2 * (j - 1) - b]};
        if (r >= {1'b0, st_d[j].f}) begin
          r = r - {1'b0, st_d[j].f};
          st_d[j].quot = {st_d[j].quot[18:0], 1'b1};
        end else begin
          st_d[j].quot = {st_d[j].quot[18:0], 1'b0};
        end
        st_d[j].rem = r[15:0];
      end
    end
    r = '0;
    out_d.frequency_hz = st_q[DIV_STAGES].f;
    out_d.period_us    = (st_q[DIV_STAGES].f == 16'd0) ? 17'd0
                         : st_q[DIV_STAGES].quot[16:0];
    out_d.duration_ms  = st_q[DIV_STAGES].dur;
    out_d.is_rest      = st_q[DIV_STAGES].rest;
    out_d.parse_error  = st_q[DIV_STAGES].err;
    out_d.melody_done  = st_q[DIV_STAGES].mel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LETTER;
      off_q     <= 5'sd0;
      oct_q     <= OCTAVE_DEFAULT;
      units_q   <= UNITS_DEFAULT;
      rest_q    <= 1'b0;
      err_q     <= ERR_NONE;
      unit_ms_q <= UNIT_MS_RESET;
      vp_q      <= 1'b0;
      vs_q      <= '0;
      vo_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unit_ms_q <= cfg_data_i;
      end
      if (accept) begin
        phase_q <= phase_d;
        off_q   <= off_d;
        oct_q   <= oct_d;
        units_q <= units_d;
        rest_q  <= rest_d;
        err_q   <= err_d;
      end
      if (rdy_p) begin
        vp_q <= accept && emit;
      end
      if (rdy_s[0]) begin
        vs_q[0] <= vp_q;
      end
      for (int j = 1; j <= DIV_STAGES; j++) begin
        if (rdy_s[j]) begin
          vs_q[j] <= vs_q[j-1];
        end
      end
      if (rdy_o) begin
        vo_q <= vs_q[DIV_STAGES];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_p) begin
      np_q <= np_d;
    end
    for (int j = 0; j <= DIV_STAGES; j++) begin
      if (rdy_s[j]) begin
        st_q[j] <= st_d[j];
      end
    end
    if (rdy_o) begin
      out_q <= out_d;
    end
  end

endmodule

/* verif/tb_melody_note_token_parser_core.sv */
// Self-checking testbench for melody_note_token_parser_core: directed and random
// character streams checked against a behavioral predictor of the note parser.
// Depends on mntp_pkg and melody_note_token_parser_core.
`timescale 1ns / 1ps

module tb_melody_note_token_parser_core;
  import mntp_pkg::*;

  typedef enum logic [2:0] {
    EXPECT_LETTER,
    IN_MODIFIERS,
    AFTER_COLON,
    IN_DIGITS,
    SKIP_REST
  } parse_phase_e;

  typedef struct {
    mntp_in_t  ch;
    bit        typed;
    mntp_out_t want;
  } script_row_t;

  localparam int RESULT_LATENCY = 12;
  localparam int DRAIN_CYCLES   = RESULT_LATENCY + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 8;
  localparam int CHARS_PER_PHASE = 112;

  // 440 Hz scaled by 64, times 2^(k/12), truncated.
  localparam int HZ_X64 [12] = '{28160, 29834, 31608, 33488, 35479, 37589,
                                 39824, 42192, 44701, 47359, 50175, 53159};
  localparam logic [7:0] NOTE_LETTERS [8] = '{CH_A, CH_B, CH_C, CH_D, CH_E, CH_F,
                                               CH_G, CH_R};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  mntp_in_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  mntp_out_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [9:0]  cfg_data_i = '0;

  parse_phase_e phase;
  int           semitone;
  int           octave;
  int           units;
  bit           rest_seen;
  logic [1:0]   err_seen;
  int           unit_ms;

  mntp_out_t    expected_notes [$];
  script_row_t  directed_rows [$];
  int           error_count = 0;
  int           idle_cycles = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           chars_sent = 0;

  melody_note_token_parser_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    mntp_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_notes.size() == 0) begin
        $error("unexpected note result %h", out_item_o);
        error_count++;
      end else begin
        want = expected_notes.pop_front();
        if (out_item_o.frequency_hz !== want.frequency_hz) begin
          $error("frequency_hz: expected %0d, got %0d", want.frequency_hz,
                 out_item_o.frequency_hz);
          error_count++;
        end
        if (out_item_o.period_us !== want.period_us) begin
          $error("period_us: expected %0d, got %0d", want.period_us, out_item_o.period_us);
          error_count++;
        end
        if (out_item_o.duration_ms !== want.duration_ms) begin
          $error("duration_ms: expected %0d, got %0d", want.duration_ms,
                 out_item_o.duration_ms);
          error_count++;
        end
        if (out_item_o.is_rest !== want.is_rest) begin
          $error("is_rest: expected %0d, got %0d", want.is_rest, out_item_o.is_rest);
          error_count++;
        end
        if (out_item_o.parse_error !== want.parse_error) begin
          $error("parse_error: expected %0d, got %0d", want.parse_error,
                 out_item_o.parse_error);
          error_count++;
        end
        if (out_item_o.melody_done !== want.melody_done) begin
          $error("melody_done: expected %0d, got %0d", want.melody_done,
                 out_item_o.melody_done);
          error_count++;
        end
      end
    end
  end

  task automatic flag_error(input logic [1:0] code);
    if (err_seen == ERR_NONE) err_seen = code;
    phase = SKIP_REST;
  endtask

  function automatic logic [15:0] tone_hz();
    int m;
    int q;
    m = (octave - 4) * 12 + semitone + 72;
    if (m < 0) m = 0;
    q = m / 12;
    if (q > 12) q = 12;
    return 16'(HZ_X64[m % 12] >> (12 - q));
  endfunction

  task automatic parse_char(input mntp_in_t it, output bit ended, output mntp_out_t note);
    logic [7:0] c;
    bit         is_digit;
    c = it.char_code;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    ended = it.last_of_note || (c == CH_NUL);
    note = '0;
    if (phase == EXPECT_LETTER) begin
      semitone = 0;
      rest_seen = 1'b0;
      err_seen = ERR_NONE;
      phase = IN_MODIFIERS;
      case (c)
        CH_A: semitone = 0;
        CH_B: semitone = 2;
        CH_C: semitone = -9;
        CH_D: semitone = -7;
        CH_E: semitone = -5;
        CH_F: semitone = -4;
        CH_G: semitone = -2;
        CH_R: rest_seen = 1'b1;
        default: flag_error(ERR_BAD_LETTER);
      endcase
    end else if (c != CH_NUL) begin
      case (phase)
        IN_MODIFIERS: begin
          if (c == CH_SHARP) begin
            if (semitone < 15) semitone++;
          end else if (c == CH_FLAT) begin
            if (semitone > -16) semitone--;
          end else if (is_digit) begin
            octave = c - CH_ZERO;
          end else if (c == CH_COLON) begin
            phase = AFTER_COLON;
          end else begin
            flag_error(ERR_BAD_MOD);
          end
        end
        AFTER_COLON: begin
          if (is_digit) begin
            units = c - CH_ZERO;
            phase = IN_DIGITS;
          end else begin
            flag_error(ERR_NO_DIGIT);
          end
        end
        IN_DIGITS: begin
          if (is_digit) begin
            units = units * 10 + (c - CH_ZERO);
            if (units > 999) units = 999;
          end else begin
            phase = SKIP_REST;
          end
        end
        default: ;
      endcase
    end
    if (ended) begin
      if (phase == AFTER_COLON) flag_error(ERR_NO_DIGIT);
      if (!rest_seen && err_seen == ERR_NONE) begin
        note.frequency_hz = tone_hz();
        note.period_us = 17'(1000000 / note.frequency_hz);
      end
      note.duration_ms = 20'(units * unit_ms);
      note.is_rest = rest_seen;
      note.parse_error = err_seen;
      note.melody_done = it.last_of_melody;
      phase = EXPECT_LETTER;
      semitone = 0;
      rest_seen = 1'b0;
      err_seen = ERR_NONE;
      if (it.last_of_melody) begin
        octave = 4;
        units = 4;
      end
    end
  endtask

  task automatic send_char(input mntp_in_t it, input bit typed, input mntp_out_t want);
    int        gap;
    bit        ended;
    mntp_out_t note;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    parse_char(it, ended, note);
    if (ended) expected_notes.push_back(typed ? want : note);
  endtask

  task automatic add_step(input logic [7:0] c, input bit ln, input bit lm, input bit typed,
                          input mntp_out_t want);
    script_row_t r;
    r.ch = mntp_in_t'{c, ln, lm};
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  task automatic write_unit_ms(input logic [9:0] value);
    in_valid_i <= 1'b0;
    while (expected_notes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    unit_ms = value;
  endtask

  task automatic send_random_note();
    logic [7:0] chars [$];
    int         kind;
    int         n;
    int         i;
    bit         mel_end;
    bit         end_nul;
    kind = $urandom_range(99);
    if (kind < 15) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        send_char(mntp_in_t'{8'($urandom), 1'($urandom), 1'($urandom)}, 1'b0, '0);
      end
    end else begin
      chars.push_back(NOTE_LETTERS[$urandom_range(7)]);
      n = ($urandom_range(19) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 3);
      repeat (n) chars.push_back($urandom_range(1) ? CH_SHARP : CH_FLAT);
      if ($urandom_range(1)) chars.push_back(8'(CH_ZERO + $urandom_range(9)));
      if ($urandom_range(2) != 0) begin
        chars.push_back(CH_COLON);
        n = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 4);
        repeat (n) chars.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      if (kind < 30) chars[$urandom_range(chars.size() - 1)] = 8'($urandom);
      mel_end = ($urandom_range(5) == 0);
      end_nul = ($urandom_range(9) == 0);
      for (i = 0; i < chars.size(); i++) begin
        if (i == chars.size() - 1 && !end_nul) begin
          send_char(mntp_in_t'{chars[i], 1'b1, mel_end}, 1'b0, '0);
        end else begin
          send_char(mntp_in_t'{chars[i], 1'b0, 1'($urandom)}, 1'b0, '0);
        end
      end
      if (end_nul) send_char(mntp_in_t'{CH_NUL, 1'($urandom), mel_end}, 1'b0, '0);
    end
  endtask

  initial begin
    logic [9:0] unit_choice;
    int         p;
    phase = EXPECT_LETTER;
    semitone = 0;
    octave = 4;
    units = 4;
    rest_seen = 1'b0;
    err_seen = ERR_NONE;
    unit_ms = 125;

    add_step(CH_A, 1, 1, 1, '{16'd440, 17'd2272, 20'd500, 1'b0, ERR_NONE, 1'b1});
    add_step(CH_R, 1, 0, 1, '{16'd0, 17'd0, 20'd500, 1'b1, ERR_NONE, 1'b0});
    add_step(8'hFF, 1, 1, 1, '{16'd0, 17'd0, 20'd500, 1'b0, ERR_BAD_LETTER, 1'b1});
    add_step(CH_NUL, 0, 1, 1, '{16'd0, 17'd0, 20'd500, 1'b0, ERR_BAD_LETTER, 1'b1});
    add_step(CH_C, 0, 1, 0, '0);
    add_step(CH_ZERO, 0, 0, 0, '0);
    add_step(CH_FLAT, 0, 0, 0, '0);
    add_step(CH_COLON, 0, 0, 0, '0);
    add_step(CH_NINE, 0, 0, 0, '0);
    add_step(CH_NINE, 0, 0, 0, '0);
    add_step(CH_NINE, 0, 0, 0, '0);
    add_step(CH_NINE, 0, 0, 0, '0);
    add_step(8'h78, 1, 0, 0, '0);
    add_step(CH_G, 0, 0, 0, '0);
    add_step(CH_COLON, 1, 0, 1, '{16'd0, 17'd0, 20'd124875, 1'b0, ERR_NO_DIGIT, 1'b0});
    add_step(CH_D, 0, 0, 0, '0);
    add_step(8'h24, 1, 1, 1, '{16'd0, 17'd0, 20'd124875, 1'b0, ERR_BAD_MOD, 1'b1});
    add_step(CH_E, 0, 0, 0, '0);
    add_step(CH_COLON, 0, 0, 0, '0);
    add_step(8'h7A, 1, 0, 1, '{16'd0, 17'd0, 20'd500, 1'b0, ERR_NO_DIGIT, 1'b0});
    add_step(CH_F, 0, 0, 0, '0);
    add_step(CH_SHARP, 0, 0, 0, '0);
    add_step(CH_NUL, 0, 1, 0, '0);
    add_step(CH_B, 0, 0, 0, '0);
    add_step(CH_NINE, 0, 0, 0, '0);
    add_step(CH_COLON, 0, 0, 0, '0);
    add_step(CH_ZERO, 1, 1, 0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_char(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: unit_choice = 10'd1;
        1: unit_choice = 10'd1000;
        2: unit_choice = 10'd0;
        3: unit_choice = 10'd1023;
        5: unit_choice = UNIT_MS_RESET;
        default: unit_choice = 10'($urandom_range(1, 1000));
      endcase
      write_unit_ms(unit_choice);
      case (p % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 53; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 53; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      chars_sent = 0;
      while (chars_sent < CHARS_PER_PHASE) send_random_note();
    end

    in_valid_i <= 1'b0;
    while (expected_notes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
